[rtl/core/multirate_sample_scheduler_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multirate sample scheduler
// Shared property forms: same-cycle and next-cycle implications on clk,
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MULTIRATE_SAMPLE_SCHEDULER_UNIT_DEFINES_SVH
`define MULTIRATE_SAMPLE_SCHEDULER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg
// Types, constants and beat layout shared by the multirate sample scheduler.
// ----------------------------------------------------------------------------
package mss_pkg;

  // Sizing
  localparam int unsigned FIFO_DEPTH_DEFAULT = 16;
  localparam int unsigned PHASE_W  = 12;
  localparam int unsigned MOD10_W  = 4;
  localparam int unsigned MOD125_W = 7;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MASK_W   = 5;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned OUT_W    = 120;

  // Phase wheel: 2500 ticks of 4 ms
  localparam logic [PHASE_W-1:0]  PHASE_LAST    = 12'd2499;
  localparam logic [MOD10_W-1:0]  MOD10_LAST    = 4'd9;
  localparam logic [MOD125_W-1:0] MOD125_LAST   = 7'd124;
  localparam logic [PHASE_W-1:0]  BATTERY_PHASE = 12'd1249;
  localparam logic [MOD10_W-1:0]  PULSE_SLOT    = 4'd0;
  localparam logic [MOD10_W-1:0]  ACCEL_SLOT    = 4'd4;
  localparam logic [MOD125_W-1:0] TEMP_SLOT     = 7'd64;
  localparam logic [MOD125_W-1:0] HALF_MID      = 7'd62;
  localparam logic [MOD125_W-1:0] HALF_END      = 7'd124;
  localparam logic [MOD125_W-1:0] HALF_TOP      = 7'd0;
  localparam logic [TIME_W-1:0]   MS_PER_TICK   = 32'd4;

  // Sensor enable bits
  localparam int unsigned EN_EEG     = 0;
  localparam int unsigned EN_PULSE   = 1;
  localparam int unsigned EN_TEMP    = 2;
  localparam int unsigned EN_ACCEL   = 3;
  localparam int unsigned EN_BATTERY = 4;

  // Output beat layout
  localparam int unsigned O_CAPTURED  = 0;
  localparam int unsigned O_PULSE     = 1;
  localparam int unsigned O_TEMP      = 2;
  localparam int unsigned O_ACCEL     = 3;
  localparam int unsigned O_BATTERY   = 4;
  localparam int unsigned O_NOTIFY    = 5;
  localparam int unsigned O_TIME_LSB  = 6;
  localparam int unsigned O_HALF_LSB  = 38;
  localparam int unsigned O_SMP_LSB   = 70;
  localparam int unsigned O_FTIME_LSB = 86;
  localparam int unsigned O_FVALID    = 118;
  localparam int unsigned O_OVERFLOW  = 119;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    HS_STEP0 = 2'd0,
    HS_STEP1 = 2'd1,
    HS_STEP2 = 2'd2,
    HS_STEP3 = 2'd3
  } hs_step_t;

  // Sensor slots reached by a tick, already gated by the enable mask
  typedef struct packed {
    logic eeg_slot;
    logic pulse;
    logic temp;
    logic accel;
    logic battery;
  } due_t;

  // Outcome of one item at the eeg fifo
  typedef struct packed {
    logic captured;
    logic overflow;
    logic notify;
    logic pop_valid;
  } fifo_stat_t;

endpackage

[rtl/core/mss_timebase.sv]
// ----------------------------------------------------------------------------
// mss_timebase
// Millisecond time, phase wheel with its mod 10 and mod 125 companions,
// sensor slot decode and the half-second mark sequencer.
// ----------------------------------------------------------------------------
module mss_timebase
  import mss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_en,
  input  cmd_t                cmd,
  input  logic [MASK_W-1:0]   mask,
  output due_t                due,
  output logic [TIME_W-1:0]   time_ms_next,
  output logic [COUNT_W-1:0]  half_count_next
);

  logic [PHASE_W-1:0]  phase;
  logic [PHASE_W-1:0]  phase_next;
  logic [MOD10_W-1:0]  mod10;
  logic [MOD10_W-1:0]  mod10_next;
  logic [MOD125_W-1:0] mod125;
  logic [MOD125_W-1:0] mod125_next;
  logic [TIME_W-1:0]   time_ms;
  logic [COUNT_W-1:0]  half_count;
  hs_step_t            hs_step;
  hs_step_t            hs_step_next;
  logic                is_tick;
  logic                is_clear;
  logic                hit;

  assign is_tick  = (cmd == CMD_TICK);
  assign is_clear = (cmd == CMD_CLEAR);

  // Advance the wheel; 2500 is a multiple of 10 and 125 so all wrap together
  always_comb begin
    phase_next   = phase;
    mod10_next   = mod10;
    mod125_next  = mod125;
    time_ms_next = time_ms;
    if (is_tick) begin
      phase_next   = (phase == PHASE_LAST) ? '0 : phase + 12'd1;
      mod10_next   = (mod10 == MOD10_LAST) ? '0 : mod10 + 4'd1;
      mod125_next  = (mod125 == MOD125_LAST) ? '0 : mod125 + 7'd1;
      time_ms_next = time_ms + MS_PER_TICK;
    end
  end

  // Decode sensor slots from the advanced phase
  always_comb begin
    due.eeg_slot = is_tick && mask[EN_EEG] && phase_next[0];
    due.pulse    = is_tick && mask[EN_PULSE] && (mod10_next == PULSE_SLOT);
    due.temp     = is_tick && mask[EN_TEMP] && (mod125_next == TEMP_SLOT);
    due.accel    = is_tick && mask[EN_ACCEL] && (mod10_next == ACCEL_SLOT);
    due.battery  = is_tick && mask[EN_BATTERY] && (phase_next == BATTERY_PHASE);
  end

  // Half-second sequencer: marks at 62, 124, 62, 0 of the mod 125 phase
  always_comb begin
    hit = 1'b0;
    case (hs_step)
      HS_STEP0: hit = (mod125_next == HALF_MID);
      HS_STEP1: hit = (mod125_next == HALF_END);
      HS_STEP2: hit = (mod125_next == HALF_MID);
      HS_STEP3: hit = (mod125_next == HALF_TOP);
      default:  hit = 1'b0;
    endcase
    hit = hit && is_tick;

    hs_step_next = hs_step;
    if (hit) begin
      case (hs_step)
        HS_STEP0: hs_step_next = HS_STEP1;
        HS_STEP1: hs_step_next = HS_STEP2;
        HS_STEP2: hs_step_next = HS_STEP3;
        HS_STEP3: hs_step_next = HS_STEP0;
        default:  hs_step_next = HS_STEP0;
      endcase
    end

    half_count_next = half_count;
    if (hit) begin
      half_count_next = half_count + 32'd1;
    end else if (is_clear) begin
      half_count_next = '0;
    end
  end

  // Commit state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      mod10      <= '0;
      mod125     <= '0;
      time_ms    <= '0;
      half_count <= '0;
      hs_step    <= HS_STEP0;
    end else if (item_en) begin
      phase      <= phase_next;
      mod10      <= mod10_next;
      mod125     <= mod125_next;
      time_ms    <= time_ms_next;
      half_count <= half_count_next;
      hs_step    <= hs_step_next;
    end
  end

endmodule

[rtl/core/mss_eeg_fifo.sv]
// ----------------------------------------------------------------------------
// mss_eeg_fifo
// Circular buffer of eeg samples with timestamps. Pointers and fill count
// in flops, entries in a single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module mss_eeg_fifo
  import mss_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_en,
  input  logic                push_req,
  input  logic                pop_req,
  input  logic [SAMPLE_W-1:0] push_sample,
  input  logic [TIME_W-1:0]   push_time,
  output fifo_stat_t          stat,
  output logic [SAMPLE_W-1:0] rd_sample,
  output logic [TIME_W-1:0]   rd_time
);

  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W = TIME_W + SAMPLE_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   count;
  logic               empty;
  logic               push_ok;
  logic               pop_ok;

  assign empty   = (count == '0);
  assign push_ok = push_req && (count != FULL_CNT);
  assign pop_ok  = pop_req && !empty;

  // Item outcome: drop on full, notify on push into empty or pop that leaves data
  always_comb begin
    stat.captured  = push_ok;
    stat.overflow  = push_req && !push_ok;
    stat.pop_valid = pop_ok;
    stat.notify    = (push_ok && empty) || (pop_ok && (count != CNT_W'(1)));
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else if (item_en) begin
      if (push_ok) begin
        wr_idx <= (wr_idx == LAST_IDX) ? '0 : wr_idx + IDX_W'(1);
        count  <= count + CNT_W'(1);
      end else if (pop_ok) begin
        rd_idx <= (rd_idx == LAST_IDX) ? '0 : rd_idx + IDX_W'(1);
        count  <= count - CNT_W'(1);
      end
    end
  end

  // Write entries
  always_ff @(posedge clk) begin
    if (item_en && push_ok) begin
      mem[wr_idx] <= {push_time, push_sample};
    end
  end

  // Read the oldest entry; held until the next pop
  always_ff @(posedge clk) begin
    if (item_en && pop_ok) begin
      {rd_time, rd_sample} <= mem[rd_idx];
    end
  end

endmodule

[rtl/core/multirate_sample_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// multirate_sample_scheduler_unit
// Tick-driven sensor scheduler with an eeg sample fifo and half-second count.
// ----------------------------------------------------------------------------
// Accepts one command beat per clock while the output is not stalled, and
// returns one result beat per command, in order. While a beat sits in the
// input register, the phase wheel, slot decode, half-second sequencer and fifo
// pointers are evaluated; they are committed as the beat moves into the result
// register, and a new beat can enter the input register at that point. The
// fifo entries sit in a memory with one registered read port that is read in
// the same step that retires a pop, so no clearing pass is needed after reset.
// The enable mask is written on its own channel and is always ready; write it
// only while no command is in flight.
module multirate_sample_scheduler_unit
  import mss_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  // Enable mask write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MASK_W-1:0]   cfg_data,      // sensor_enable_mask
  // Command beats
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,  // eeg_sample
  input  logic [CMD_W-1:0]    s_axis_tuser,  // cmd
  // Result beats
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // eeg_captured, pulse_due, temp_due, accel_due, battery_due, eeg_notify,
  // time_ms[32], half_second_count[32], fifo_sample[16], fifo_time[32],
  // fifo_valid, fifo_overflow
  output logic [OUT_W-1:0]    m_axis_tdata
);

  logic [MASK_W-1:0]   mask;
  logic                in_valid;
  cmd_t                in_cmd;
  logic [SAMPLE_W-1:0] in_sample;
  logic                res_valid;
  logic                res_room;
  logic                item_en;
  due_t                due;
  fifo_stat_t          stat;
  logic [TIME_W-1:0]   time_ms_next;
  logic [COUNT_W-1:0]  half_count_next;
  logic [SAMPLE_W-1:0] rd_sample;
  logic [TIME_W-1:0]   rd_time;
  due_t                res_due;
  fifo_stat_t          res_stat;
  logic [TIME_W-1:0]   res_time;
  logic [COUNT_W-1:0]  res_half;

  // Enable mask register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mask <= cfg_data;
    end
  end

  // Handshake: result register frees as it is taken
  assign res_room      = !res_valid || m_axis_tready;
  assign item_en       = in_valid && res_room;
  assign s_axis_tready = !in_valid || res_room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (item_en) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd    <= cmd_t'(s_axis_tuser);
      in_sample <= s_axis_tdata;
    end
  end

  mss_timebase u_timebase (
    .clk             (clk),
    .rst             (rst),
    .item_en         (item_en),
    .cmd             (in_cmd),
    .mask            (mask),
    .due             (due),
    .time_ms_next    (time_ms_next),
    .half_count_next (half_count_next)
  );

  mss_eeg_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_eeg_fifo (
    .clk         (clk),
    .rst         (rst),
    .item_en     (item_en),
    .push_req    (due.eeg_slot),
    .pop_req     (in_cmd == CMD_POP),
    .push_sample (in_sample),
    .push_time   (time_ms_next),
    .stat        (stat),
    .rd_sample   (rd_sample),
    .rd_time     (rd_time)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item_en) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_en) begin
      res_due  <= due;
      res_stat <= stat;
      res_time <= time_ms_next;
      res_half <= half_count_next;
    end
  end

  // Assemble the result beat; popped fields read zero unless the pop hit data
  assign m_axis_tvalid = res_valid;

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[O_CAPTURED] = res_stat.captured;
    m_axis_tdata[O_PULSE]    = res_due.pulse;
    m_axis_tdata[O_TEMP]     = res_due.temp;
    m_axis_tdata[O_ACCEL]    = res_due.accel;
    m_axis_tdata[O_BATTERY]  = res_due.battery;
    m_axis_tdata[O_NOTIFY]   = res_stat.notify;
    m_axis_tdata[O_TIME_LSB +: TIME_W]  = res_time;
    m_axis_tdata[O_HALF_LSB +: COUNT_W] = res_half;
    m_axis_tdata[O_SMP_LSB +: SAMPLE_W] = res_stat.pop_valid ? rd_sample : '0;
    m_axis_tdata[O_FTIME_LSB +: TIME_W] = res_stat.pop_valid ? rd_time : '0;
    m_axis_tdata[O_FVALID]   = res_stat.pop_valid;
    m_axis_tdata[O_OVERFLOW] = res_stat.overflow;
  end

endmodule

[rtl/core/mss_checker.sv]
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks for the multirate sample scheduler, bound to the top.
// ----------------------------------------------------------------------------
`include "multirate_sample_scheduler_unit_defines.svh"

module mss_checker
  import mss_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OUT_W-1:0]    m_axis_tdata
);

  logic pop_miss;
  logic pop_fields_zero;
  logic notify_source;
  logic push_clash;

  assign pop_miss        = m_axis_tvalid && !m_axis_tdata[O_FVALID];
  assign pop_fields_zero = (m_axis_tdata[O_SMP_LSB +: SAMPLE_W] == '0) &&
                           (m_axis_tdata[O_FTIME_LSB +: TIME_W] == '0);
  assign notify_source   = m_axis_tdata[O_CAPTURED] || m_axis_tdata[O_FVALID];
  assign push_clash      = m_axis_tdata[O_CAPTURED] && m_axis_tdata[O_OVERFLOW];

  // Stalled result beat holds
  `MSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // Popped fields are zero unless the pop returned an entry
  `MSS_ASSERT_SAME(a_pop_zero, pop_miss, pop_fields_zero, "popped fields set without a valid entry")

  // Notify only comes from a push or a pop that returned data
  `MSS_ASSERT_SAME(a_notify_src, m_axis_tvalid && m_axis_tdata[O_NOTIFY], notify_source, "notify without push or pop")

  // A sample is either stored or dropped, never both
  `MSS_ASSERT_SAME(a_push_excl, m_axis_tvalid, !push_clash, "sample both captured and dropped")

  // An empty result register never blocks the input side
  `MSS_ASSERT_SAME(a_in_ready, !m_axis_tvalid, s_axis_tready, "input stalled with free result register")

endmodule

bind multirate_sample_scheduler_unit mss_checker u_mss_checker (.*);
